// File: rtl/pprd_pkg.sv
// ----------------------------------------------------------------------------
// pprd_pkg
// Shared types and constants of the paper presence row debouncer: register
// indexes, edge event codes, window sizes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pprd_pkg;

  // Default geometry
  localparam int unsigned MaxRowWidth  = 4096;
  localparam int unsigned SideWindow   = 50;
  localparam int unsigned CenterWindow = 250;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned StartW   = 12;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned CountW   = 8;

  // Register reset values
  localparam logic [StartW-1:0] StartReset = '0;
  localparam logic [LevelW-1:0] LevelReset = 8'd128;
  localparam logic [CountW-1:0] EnterReset = 8'd4;
  localparam logic [CountW-1:0] ExitReset  = 8'd4;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT_START   = 3'd0,
    CFG_RIGHT_START  = 3'd1,
    CFG_CENTER_START = 3'd2,
    CFG_LEFT_LEVEL   = 3'd3,
    CFG_RIGHT_LEVEL  = 3'd4,
    CFG_CENTER_LEVEL = 3'd5,
    CFG_ENTER_COUNT  = 3'd6,
    CFG_EXIT_COUNT   = 3'd7
  } cfg_idx_e;

  // Edge event codes
  typedef enum logic [1:0] {
    EDGE_NONE  = 2'd0,
    EDGE_ENTER = 2'd1,
    EDGE_EXIT  = 2'd2
  } edge_e;

endpackage

`default_nettype wire

// File: rtl/paper_presence_row_debouncer.sv
// ----------------------------------------------------------------------------
// paper_presence_row_debouncer
// Sums three column windows of each camera row, checks the background
// pattern and debounces paper entry and exit, one result beat per row.
// ----------------------------------------------------------------------------
// Pixels stream in one per cycle in row order; a row_end beat closes the
// row and produces exactly one result beat carrying the presence flag after
// that row and an edge event (none, entered, exited). Every other pixel beat
// produces nothing. Throughput is one pixel per clock while the input side
// does not stall: a pixel is held in the input register, then the window
// adders, the pattern compare and the debounce counter update state as it
// leaves, and a row_end beat loads the result register, which presents the
// result beat until it is taken.
// The input side stalls only while the result register holds an untaken
// result and the pixel waiting in the input register closes another row.
// Configuration writes are taken at any time (cfg_ready_o is always high)
// but must only happen while the block is idle; every index names one
// register. Windows that run past the row end sum only the pixels received;
// rows longer than MAX_ROW_WIDTH wrap the column count and saturate sums.
`default_nettype none

module paper_presence_row_debouncer #(
  parameter int unsigned MAX_ROW_WIDTH = pprd_pkg::MaxRowWidth,
  parameter int unsigned SIDE_WINDOW   = pprd_pkg::SideWindow,
  parameter int unsigned CENTER_WINDOW = pprd_pkg::CenterWindow
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // pixel channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    pixel_i,
  input  wire logic                          row_end_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               paper_present_o,
  output logic [1:0]                         edge_event_o,
  // configuration channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pprd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [pprd_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned ColW       = $clog2(MAX_ROW_WIDTH);
  localparam int unsigned SideCap    = SIDE_WINDOW * 255;
  localparam int unsigned CenterCap  = CENTER_WINDOW * 255;
  localparam int unsigned SideSumW   = $clog2(SideCap + 1);
  localparam int unsigned CenterSumW = $clog2(CenterCap + 1);
  localparam int unsigned WinW       = $clog2(CENTER_WINDOW + 1);
  localparam int unsigned BaseW      = (ColW > pprd_pkg::StartW) ? ColW : pprd_pkg::StartW;
  localparam int unsigned CmpW       = ((BaseW > WinW) ? BaseW : WinW) + 1;

  localparam logic [ColW-1:0]       ColLast   = ColW'(MAX_ROW_WIDTH - 1);
  localparam logic [SideSumW-1:0]   SideMax   = SideSumW'(SideCap);
  localparam logic [CenterSumW-1:0] CenterMax = CenterSumW'(CenterCap);
  localparam logic [CmpW-1:0]       SideWinX  = CmpW'(SIDE_WINDOW);
  localparam logic [CmpW-1:0]       CentWinX  = CmpW'(CENTER_WINDOW);
  localparam logic [SideSumW-1:0]   SideMul   = SideSumW'(SIDE_WINDOW);
  localparam logic [CenterSumW-1:0] CentMul   = CenterSumW'(CENTER_WINDOW);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [pprd_pkg::StartW-1:0] left_start_q, right_start_q, center_start_q;
  logic [pprd_pkg::LevelW-1:0] left_level_q, right_level_q, center_level_q;
  logic [pprd_pkg::CountW-1:0] enter_count_q, exit_count_q;
  pprd_pkg::cfg_idx_e          cfg_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = pprd_pkg::cfg_idx_e'(cfg_index_i);

  // Write the addressed register on a config beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_start_q   <= pprd_pkg::StartReset;
      right_start_q  <= pprd_pkg::StartReset;
      center_start_q <= pprd_pkg::StartReset;
      left_level_q   <= pprd_pkg::LevelReset;
      right_level_q  <= pprd_pkg::LevelReset;
      center_level_q <= pprd_pkg::LevelReset;
      enter_count_q  <= pprd_pkg::EnterReset;
      exit_count_q   <= pprd_pkg::ExitReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx)
        pprd_pkg::CFG_LEFT_START:   left_start_q   <= cfg_data_i;
        pprd_pkg::CFG_RIGHT_START:  right_start_q  <= cfg_data_i;
        pprd_pkg::CFG_CENTER_START: center_start_q <= cfg_data_i;
        pprd_pkg::CFG_LEFT_LEVEL:   left_level_q   <= cfg_data_i[pprd_pkg::LevelW-1:0];
        pprd_pkg::CFG_RIGHT_LEVEL:  right_level_q  <= cfg_data_i[pprd_pkg::LevelW-1:0];
        pprd_pkg::CFG_CENTER_LEVEL: center_level_q <= cfg_data_i[pprd_pkg::LevelW-1:0];
        pprd_pkg::CFG_ENTER_COUNT:  enter_count_q  <= cfg_data_i[pprd_pkg::CountW-1:0];
        pprd_pkg::CFG_EXIT_COUNT:   exit_count_q   <= cfg_data_i[pprd_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       s1_valid_q;
  logic [7:0] s1_pixel_q;
  logic       s1_last_q;
  logic       s1_adv;
  logic       in_fire;

  // Advance unless a row result would overwrite an untaken one
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pixel_q <= pixel_i;
      s1_last_q  <= row_end_i;
    end
  end

  // --------------------------------------------------------------------------
  // Window accumulation
  // --------------------------------------------------------------------------
  logic [ColW-1:0]       col_q, col_d;
  logic [SideSumW-1:0]   left_sum_q, right_sum_q, left_sum_d, right_sum_d;
  logic [CenterSumW-1:0] center_sum_q, center_sum_d;
  logic [CmpW-1:0]       col_x, left_x, right_x, center_x;
  logic                  left_hit, right_hit, center_hit;
  logic [SideSumW:0]     left_add, right_add;
  logic [CenterSumW:0]   center_add;

  assign col_x    = CmpW'(col_q);
  assign left_x   = CmpW'(left_start_q);
  assign right_x  = CmpW'(right_start_q);
  assign center_x = CmpW'(center_start_q);

  assign left_hit   = (col_x >= left_x) && (col_x < left_x + SideWinX);
  assign right_hit  = (col_x >= right_x) && (col_x < right_x + SideWinX);
  assign center_hit = (col_x >= center_x) && (col_x < center_x + CentWinX);

  assign left_add   = {1'b0, left_sum_q} + (SideSumW + 1)'(s1_pixel_q);
  assign right_add  = {1'b0, right_sum_q} + (SideSumW + 1)'(s1_pixel_q);
  assign center_add = {1'b0, center_sum_q} + (CenterSumW + 1)'(s1_pixel_q);

  // Add the pixel into each window it falls in, saturating at the cap
  always_comb begin
    left_sum_d   = left_sum_q;
    right_sum_d  = right_sum_q;
    center_sum_d = center_sum_q;
    if (left_hit) begin
      left_sum_d = (left_add > {1'b0, SideMax}) ? SideMax : left_add[SideSumW-1:0];
    end
    if (right_hit) begin
      right_sum_d = (right_add > {1'b0, SideMax}) ? SideMax : right_add[SideSumW-1:0];
    end
    if (center_hit) begin
      center_sum_d = (center_add > {1'b0, CenterMax}) ? CenterMax
                                                      : center_add[CenterSumW-1:0];
    end
  end

  // Advance the column, wrapping at the maximum row width
  assign col_d = (col_q == ColLast) ? '0 : col_q + ColW'(1);

  // --------------------------------------------------------------------------
  // Pattern check and debounce
  // --------------------------------------------------------------------------
  logic                        pattern;
  logic                        paper_q, paper_d;
  logic [pprd_pkg::CountW-1:0] deb_q, deb_d, deb_inc, deb_dec;
  pprd_pkg::edge_e             edge_d;

  assign pattern = (left_sum_d > SideSumW'(left_level_q) * SideMul)
                && (right_sum_d > SideSumW'(right_level_q) * SideMul)
                && (center_sum_d < CenterSumW'(center_level_q) * CentMul);

  assign deb_inc = deb_q + pprd_pkg::CountW'(1);
  assign deb_dec = deb_q - pprd_pkg::CountW'(1);

  // Count background-free rows up to entry, pattern rows down to exit
  always_comb begin
    paper_d = paper_q;
    deb_d   = deb_q;
    edge_d  = pprd_pkg::EDGE_NONE;
    if (!paper_q) begin
      if (!pattern) begin
        deb_d = deb_inc;
        if (deb_inc == enter_count_q) begin
          paper_d = 1'b1;
          edge_d  = pprd_pkg::EDGE_ENTER;
        end
      end else begin
        deb_d = '0;
      end
    end else begin
      if (pattern) begin
        deb_d = deb_dec;
        if (deb_dec == '0) begin
          paper_d = 1'b0;
          edge_d  = pprd_pkg::EDGE_EXIT;
        end
      end else begin
        deb_d = exit_count_q;
      end
    end
  end

  // Update row state on each advancing pixel; clear it at row end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      left_sum_q   <= '0;
      right_sum_q  <= '0;
      center_sum_q <= '0;
      paper_q      <= 1'b0;
      deb_q        <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        col_q        <= '0;
        left_sum_q   <= '0;
        right_sum_q  <= '0;
        center_sum_q <= '0;
        paper_q      <= paper_d;
        deb_q        <= deb_d;
      end else begin
        col_q        <= col_d;
        left_sum_q   <= left_sum_d;
        right_sum_q  <= right_sum_d;
        center_sum_q <= center_sum_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic            out_valid_q;
  logic            out_paper_q;
  pprd_pkg::edge_e out_edge_q;
  logic            out_load;

  assign out_load = s1_adv && s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_paper_q <= paper_d;
      out_edge_q  <= edge_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign paper_present_o = out_paper_q;
  assign edge_event_o    = out_edge_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_enter_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_edge_q == pprd_pkg::EDGE_ENTER) |-> paper_present_o)
    else $error("entry event without paper present");

  a_exit_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_edge_q == pprd_pkg::EDGE_EXIT) |-> !paper_present_o)
    else $error("exit event with paper still present");

  a_flag_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_load) |-> (out_paper_q == paper_q))
    else $error("result flag differs from presence state");

  a_sum_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_sum_q <= SideMax) && (right_sum_q <= SideMax) && (center_sum_q <= CenterMax))
    else $error("window sum above its cap");

endmodule

`default_nettype wire
